>>> sv/oasq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offboard arming sequencer package
// Shared types, codes and register defaults for the arming sequencer block.
// ----------------------------------------------------------------------------
package oasq_pkg;

	// default width of the tick counters
	localparam int COUNT_BITS_DEF = 8;

	// configuration register indexes
	localparam logic [1:0] CFG_TILT_THRESHOLD    = 2'd0;
	localparam logic [1:0] CFG_MODE_SWITCH_COUNT = 2'd1;
	localparam logic [1:0] CFG_STREAM_TICKS      = 2'd2;
	localparam logic [1:0] CFG_LOSS_TICKS        = 2'd3;

	// configuration reset values
	localparam logic [14:0] TILT_THRESHOLD_RST    = 15'd16384;
	localparam logic [7:0]  MODE_SWITCH_COUNT_RST = 8'd10;
	localparam logic [7:0]  STREAM_TICKS_RST      = 8'd10;
	localparam logic [7:0]  LOSS_TICKS_RST        = 8'd10;

	// set-mode command codes
	localparam logic [1:0] SET_MODE_NONE     = 2'd0;
	localparam logic [1:0] SET_MODE_OFFBOARD = 2'd1;
	localparam logic [1:0] SET_MODE_HOLD     = 2'd2;

	// reported sequencer state codes
	localparam logic [1:0] SEQ_CODE_INIT     = 2'd0;
	localparam logic [1:0] SEQ_CODE_ARM      = 2'd1;
	localparam logic [1:0] SEQ_CODE_OFFBOARD = 2'd2;
	localparam logic [1:0] SEQ_CODE_DISARM   = 2'd3;

	typedef enum logic [3:0] {
		ST_INIT     = 4'b0001,
		ST_ARM      = 4'b0010,
		ST_OFFBOARD = 4'b0100,
		ST_DISARM   = 4'b1000
	} seq_state_t;

	// one tick snapshot
	typedef struct packed {
		logic        is_landed;
		logic        has_failure;
		logic        nav_auto_land;
		logic        nav_offboard;
		logic        is_armed;
		logic [15:0] pitch_demand;
		logic [15:0] roll_demand;
		logic        cmd_enable;
		logic        cmd_present;
	} tick_t;

	// command tracker results for the current tick
	typedef struct packed {
		logic enable_hold;
		logic mode_kind;
		logic tilt_active;
		logic cmd_lost;
	} track_t;

	// sequencer results for the current tick
	typedef struct packed {
		logic       stream_mode;
		logic       arm_request;
		logic       disarm_request;
		logic [1:0] set_mode_code;
		logic [1:0] seq_state;
	} seq_out_t;

	// magnitude of a signed Q1.15 value; -1.0 maps to 32768
	function automatic logic [15:0] magnitude16(input logic [15:0] v);
		logic [15:0] m;
		m = v[15] ? (~v + 16'd1) : v;
		return m;
	endfunction

endpackage

>>> sv/oasq_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command tracker
// Tilt hysteresis counter, command loss counter and held enable bit.
// ----------------------------------------------------------------------------
module oasq_track #(
	parameter int COUNT_BITS = oasq_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  oasq_pkg::tick_t     tick,
	input  logic [14:0]         tilt_threshold,
	input  logic [7:0]          mode_switch_count,
	input  logic [7:0]          loss_ticks,
	output oasq_pkg::track_t    trk
);
	localparam int CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0] tilt_q, tilt_d;
	logic [COUNT_BITS-1:0] loss_q, loss_d;
	logic                  hold_q, hold_d;
	logic                  tilted;
	logic [CMP_BITS-1:0]   tilt_x, tilt_dx, loss_x, loss_dx, msc_x, lt_x;

	assign tilted = (oasq_pkg::magnitude16(tick.roll_demand) > {1'b0, tilt_threshold}) ||
		(oasq_pkg::magnitude16(tick.pitch_demand) > {1'b0, tilt_threshold});

	assign tilt_x  = CMP_BITS'(tilt_q);
	assign loss_x  = CMP_BITS'(loss_q);
	assign msc_x   = CMP_BITS'(mode_switch_count);
	assign lt_x    = CMP_BITS'(loss_ticks);
	assign tilt_dx = CMP_BITS'(tilt_d);
	assign loss_dx = CMP_BITS'(loss_d);

	always_comb begin
		tilt_d = tilt_q;
		loss_d = loss_q;
		hold_d = hold_q;
		if (tick.cmd_present) begin
			loss_d = '0;
			hold_d = tick.cmd_enable;
			if (tilted) begin
				if (tilt_x < msc_x && tilt_q != CNT_MAX) begin
					tilt_d = tilt_q + 1'b1;
				end
			end else if (tilt_q != '0) begin
				tilt_d = tilt_q - 1'b1;
			end
		end else begin
			tilt_d = '0;
			if (loss_x <= lt_x && loss_q != CNT_MAX) begin
				loss_d = loss_q + 1'b1;
			end
		end
	end

	assign trk.enable_hold = hold_d;
	assign trk.mode_kind   = tick.cmd_present && (tilt_dx >= msc_x);
	assign trk.tilt_active = (tilt_d != '0);
	assign trk.cmd_lost    = (loss_dx >= lt_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q <= '0;
			loss_q <= '0;
			hold_q <= 1'b0;
		end else if (advance) begin
			tilt_q <= tilt_d;
			loss_q <= loss_d;
			hold_q <= hold_d;
		end
	end

endmodule

>>> sv/oasq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arming sequencer
// INIT / ARM / OFFBOARD / DISARM state machine with stream counter.
// ----------------------------------------------------------------------------
module oasq_seq #(
	parameter int COUNT_BITS = oasq_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  oasq_pkg::tick_t     tick,
	input  logic                enable_hold,
	input  logic [7:0]          stream_ticks,
	output oasq_pkg::seq_out_t  seq
);
	localparam int CMP_BITS = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	oasq_pkg::seq_state_t  state_q, state_d;
	logic                  entry_q, entry_d;
	logic [COUNT_BITS-1:0] sc_q, sc_d, sc_base;

	assign sc_base = entry_q ? '0 : sc_q;

	always_comb begin
		state_d = state_q;
		entry_d = 1'b0;
		sc_d    = sc_q;
		seq.stream_mode    = 1'b0;
		seq.arm_request    = 1'b0;
		seq.disarm_request = 1'b0;
		seq.set_mode_code  = oasq_pkg::SET_MODE_NONE;
		case (state_q)
			oasq_pkg::ST_INIT: begin
				if (!enable_hold) begin
					sc_d    = '0;
					state_d = oasq_pkg::ST_DISARM;
					entry_d = 1'b1;
				end else begin
					seq.stream_mode = 1'b1;
					sc_d = (sc_base == CNT_MAX) ? sc_base : sc_base + 1'b1;
				end
				// stream run complete: go arm, even over a drop to DISARM
				if (CMP_BITS'(sc_d) >= CMP_BITS'(stream_ticks)) begin
					state_d = oasq_pkg::ST_ARM;
					entry_d = 1'b1;
				end
			end
			oasq_pkg::ST_ARM: begin
				if (!enable_hold) begin
					sc_d    = '0;
					state_d = oasq_pkg::ST_DISARM;
					entry_d = 1'b1;
				end else if (tick.is_armed) begin
					state_d = oasq_pkg::ST_OFFBOARD;
					entry_d = 1'b1;
				end else begin
					seq.stream_mode = 1'b1;
					seq.arm_request = !tick.has_failure;
				end
			end
			oasq_pkg::ST_OFFBOARD: begin
				if (entry_q) begin
					seq.set_mode_code = oasq_pkg::SET_MODE_OFFBOARD;
				end
				if (enable_hold) begin
					if (!tick.is_armed || !tick.nav_offboard) begin
						state_d = oasq_pkg::ST_INIT;
						entry_d = 1'b1;
					end else begin
						seq.stream_mode = 1'b1;
					end
				end else begin
					state_d = oasq_pkg::ST_DISARM;
					entry_d = 1'b1;
				end
			end
			oasq_pkg::ST_DISARM: begin
				seq.set_mode_code  = oasq_pkg::SET_MODE_HOLD;
				seq.disarm_request = tick.is_armed && tick.nav_auto_land && tick.is_landed;
				if (enable_hold) begin
					state_d = oasq_pkg::ST_INIT;
					entry_d = 1'b1;
				end
			end
			default: begin
				state_d = oasq_pkg::ST_INIT;
				entry_d = 1'b1;
			end
		endcase

		case (state_d)
			oasq_pkg::ST_INIT:     seq.seq_state = oasq_pkg::SEQ_CODE_INIT;
			oasq_pkg::ST_ARM:      seq.seq_state = oasq_pkg::SEQ_CODE_ARM;
			oasq_pkg::ST_OFFBOARD: seq.seq_state = oasq_pkg::SEQ_CODE_OFFBOARD;
			oasq_pkg::ST_DISARM:   seq.seq_state = oasq_pkg::SEQ_CODE_DISARM;
			default:               seq.seq_state = oasq_pkg::SEQ_CODE_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oasq_pkg::ST_INIT;
			entry_q <= 1'b1;
			sc_q    <= '0;
		end else if (advance) begin
			state_q <= state_d;
			entry_q <= entry_d;
			sc_q    <= sc_d;
		end
	end

endmodule

>>> sv/offboard_arming_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offboard arming sequencer unit
// Per-tick arming / offboard sequencer with tilt and command loss tracking.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick snapshot per control cycle; m_axis returns exactly
//   one result per tick, in order. A request is taken at a clock edge where
//   tvalid and tready are both high.
//   The tick lands in an input register (_s1); one pass of shallow compare and
//   counter logic then writes the result register and updates the sequencer
//   and counter state together. Throughput is one tick per cycle while the
//   receiver does not stall, set by the single state update per tick.
//   When the receiver stalls, the result register holds, the input register
//   fills and s_axis_tready drops only once both are occupied.
//   cfg_we writes register cfg_index (0 tilt_threshold, 1 mode_switch_count,
//   2 stream_ticks, 3 loss_ticks) on the clock edge; write only while idle.
//   arst_n restores the register defaults, puts the sequencer in INIT with its
//   entry flag set, clears all counters and the held enable bit, and empties
//   both register stages.
// ----------------------------------------------------------------------------
module offboard_arming_sequencer_unit #(
	parameter int COUNT_BITS = oasq_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] cmd_present, [1] cmd_enable, [17:2] roll_demand, [33:18] pitch_demand,
	// [34] is_armed, [35] nav_offboard, [36] nav_auto_land, [37] has_failure,
	// [38] is_landed, [39] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] stream_mode, [1] setpoint_kind, [2] mode_kind, [3] arm_request,
	// [4] disarm_request, [6:5] set_mode_code, [8:7] seq_state, [9] cmd_lost,
	// [15:10] zero
	output logic [15:0] m_axis_tdata
);

	// configuration registers
	logic [14:0] tilt_threshold_q;
	logic [7:0]  mode_switch_count_q;
	logic [7:0]  stream_ticks_q;
	logic [7:0]  loss_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_threshold_q    <= oasq_pkg::TILT_THRESHOLD_RST;
			mode_switch_count_q <= oasq_pkg::MODE_SWITCH_COUNT_RST;
			stream_ticks_q      <= oasq_pkg::STREAM_TICKS_RST;
			loss_ticks_q        <= oasq_pkg::LOSS_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				oasq_pkg::CFG_TILT_THRESHOLD:    tilt_threshold_q    <= cfg_data;
				oasq_pkg::CFG_MODE_SWITCH_COUNT: mode_switch_count_q <= cfg_data[7:0];
				oasq_pkg::CFG_STREAM_TICKS:      stream_ticks_q      <= cfg_data[7:0];
				oasq_pkg::CFG_LOSS_TICKS:        loss_ticks_q        <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input stage
	oasq_pkg::tick_t tick_s1;
	logic            valid_s1;
	logic            advance;
	logic            in_take;

	// advance the held tick when the result register is free or being drained
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload needs no reset; load on every taken request
	always_ff @(posedge clk) begin
		if (in_take) begin
			tick_s1 <= oasq_pkg::tick_t'(s_axis_tdata[38:0]);
		end
	end

	// per-tick logic
	oasq_pkg::track_t   trk;
	oasq_pkg::seq_out_t seq;

	oasq_track #(
		.COUNT_BITS(COUNT_BITS)
	) u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.advance          (advance),
		.tick             (tick_s1),
		.tilt_threshold   (tilt_threshold_q),
		.mode_switch_count(mode_switch_count_q),
		.loss_ticks       (loss_ticks_q),
		.trk              (trk)
	);

	oasq_seq #(
		.COUNT_BITS(COUNT_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.tick        (tick_s1),
		.enable_hold (trk.enable_hold),
		.stream_ticks(stream_ticks_q),
		.seq         (seq)
	);

	// result stage
	logic [9:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// setpoint kind only shows while streaming
			result_q <= {trk.cmd_lost, seq.seq_state, seq.set_mode_code,
				seq.disarm_request, seq.arm_request, trk.mode_kind,
				seq.stream_mode && trk.tilt_active, seq.stream_mode};
		end
	end

	assign m_axis_tdata = {6'd0, result_q};

endmodule
